// ===== design/csvt_pkg.sv =====
package csvt_pkg;

    // Default width of the byte position counter
    localparam int POSITION_BITS_DEF = 16;

    // Output field widths
    localparam int OFFSET_W = 16;
    localparam int INDEX_W  = 8;

    // Field limit register after reset
    localparam logic [INDEX_W-1:0] FIELD_LIMIT_RESET = 8'd16;

    // Result queue depth (two results can be pushed per byte)
    localparam int RES_DEPTH = 4;
    localparam int RES_PTR_W = $clog2(RES_DEPTH);
    localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

    // Character codes
    localparam logic [7:0] CHAR_QUOTE = 8'h22;
    localparam logic [7:0] CHAR_COMMA = 8'h2c;
    localparam logic [7:0] CHAR_LF    = 8'h0a;
    localparam logic [7:0] CHAR_CR    = 8'h0d;

    // Parser mode
    typedef enum logic [2:0] {
        MODE_START       = 3'd0,
        MODE_UNQUOTED    = 3'd1,
        MODE_QUOTED      = 3'd2,
        MODE_AFTER_QUOTE = 3'd3,
        MODE_AFTER_CR    = 3'd4
    } csvt_mode_t;

    // One field record
    typedef struct packed {
        logic [OFFSET_W-1:0] field_start;
        logic [OFFSET_W-1:0] field_length;
        logic [INDEX_W-1:0]  field_index;
        logic                row_end;
        logic                position_overflow;
        logic                last_of_run;
    } csvt_rec_t;

endpackage

// ===== design/csvt_step.sv =====
module csvt_step #(
    parameter int POSITION_BITS = csvt_pkg::POSITION_BITS_DEF
) (
    input  logic [7:0]                          data_byte,
    input  logic                                end_of_buffer,
    input  logic [csvt_pkg::INDEX_W-1:0]        field_limit,
    // current parser state
    input  logic [POSITION_BITS-1:0]            pos,
    input  csvt_pkg::csvt_mode_t                mode,
    input  logic [POSITION_BITS-1:0]            cur_start,
    input  logic [POSITION_BITS-1:0]            cur_len,
    input  logic [csvt_pkg::INDEX_W-1:0]        cur_index,
    input  logic                                cur_ovf,
    // next parser state
    output logic [POSITION_BITS-1:0]            pos_next,
    output csvt_pkg::csvt_mode_t                mode_next,
    output logic [POSITION_BITS-1:0]            start_next,
    output logic [POSITION_BITS-1:0]            len_next,
    output logic [csvt_pkg::INDEX_W-1:0]        index_next,
    output logic                                ovf_next,
    // up to two records, in order
    output logic                                emit_a,
    output csvt_pkg::csvt_rec_t                 rec_a,
    output logic                                emit_b,
    output csvt_pkg::csvt_rec_t                 rec_b
);

    localparam logic [POSITION_BITS-1:0] POS_MAX = '1;
    localparam logic [POSITION_BITS-1:0] POS_ONE = {{(POSITION_BITS-1){1'b0}}, 1'b1};
    localparam logic [POSITION_BITS-1:0] POS_TWO = {{(POSITION_BITS-2){1'b0}}, 2'b10};

    // Saturating add; top bit of the result flags saturation
    function automatic logic [POSITION_BITS:0] sat_add(
        input logic [POSITION_BITS-1:0] a,
        input logic [POSITION_BITS-1:0] b
    );
        logic [POSITION_BITS:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return {sum[POSITION_BITS], sum[POSITION_BITS] ? POS_MAX : sum[POSITION_BITS-1:0]};
    endfunction

    logic [csvt_pkg::INDEX_W-1:0] limit;
    logic                         is_quote, is_comma, is_lf, is_cr;
    logic                         flush, a_close, b_close, b_row, unq;
    logic [POSITION_BITS:0]       sum;
    csvt_pkg::csvt_mode_t         mode_b, m_v;
    logic [POSITION_BITS-1:0]     s_v, l_v;
    logic [csvt_pkg::INDEX_W-1:0] i_v;
    logic                         o_v;

    always_comb begin
        limit    = (field_limit == '0) ? csvt_pkg::INDEX_W'(1) : field_limit;
        is_quote = (data_byte == csvt_pkg::CHAR_QUOTE);
        is_comma = (data_byte == csvt_pkg::CHAR_COMMA);
        is_lf    = (data_byte == csvt_pkg::CHAR_LF);
        is_cr    = (data_byte == csvt_pkg::CHAR_CR);

        // A held field (after CR or after a closing quote) ends before this byte
        flush = ((mode == csvt_pkg::MODE_AFTER_CR) && !is_lf) ||
                ((mode == csvt_pkg::MODE_AFTER_QUOTE) &&
                 !(is_quote || is_comma || is_lf || is_cr));

        a_close = ({1'b0, cur_index} + 9'd1) >= {1'b0, limit};
        rec_a.field_start       = csvt_pkg::OFFSET_W'(cur_start);
        rec_a.field_length      = csvt_pkg::OFFSET_W'(cur_len);
        rec_a.field_index       = cur_index;
        rec_a.row_end           = a_close;
        rec_a.position_overflow = cur_ovf;
        rec_a.last_of_run       = 1'b0;
        emit_a                  = flush;

        s_v = cur_start;
        l_v = cur_len;
        i_v = cur_index;
        o_v = cur_ovf;
        if (flush) begin
            i_v = a_close ? '0 : csvt_pkg::INDEX_W'(cur_index + 8'd1);
            l_v = '0;
        end
        mode_b = flush ? csvt_pkg::MODE_START : mode;
        m_v    = mode_b;

        // Byte in its mode
        emit_b = 1'b0;
        b_row  = 1'b0;
        unq    = 1'b0;
        sum    = '0;
        unique case (mode_b)
            csvt_pkg::MODE_AFTER_CR: begin
                // only LF remains here: consumed, closes the row
                emit_b = 1'b1;
                b_row  = 1'b1;
            end
            csvt_pkg::MODE_AFTER_QUOTE: begin
                if (is_quote) begin
                    sum = sat_add(l_v, POS_TWO);
                    l_v = sum[POSITION_BITS-1:0];
                    o_v = o_v | sum[POSITION_BITS];
                    m_v = csvt_pkg::MODE_QUOTED;
                    emit_b = end_of_buffer;
                    b_row  = 1'b1;
                end else if (is_comma) begin
                    emit_b = 1'b1;
                    b_row  = end_of_buffer;
                end else if (is_lf) begin
                    emit_b = 1'b1;
                    b_row  = 1'b1;
                end else begin
                    // CR
                    emit_b = end_of_buffer;
                    b_row  = 1'b1;
                    if (!end_of_buffer) begin
                        m_v = csvt_pkg::MODE_AFTER_CR;
                    end
                end
            end
            csvt_pkg::MODE_QUOTED: begin
                if (is_quote) begin
                    emit_b = end_of_buffer;
                    b_row  = 1'b1;
                    if (!end_of_buffer) begin
                        m_v = csvt_pkg::MODE_AFTER_QUOTE;
                    end
                end else begin
                    sum = sat_add(l_v, POS_ONE);
                    l_v = sum[POSITION_BITS-1:0];
                    o_v = o_v | sum[POSITION_BITS];
                    emit_b = end_of_buffer;
                    b_row  = 1'b1;
                end
            end
            csvt_pkg::MODE_UNQUOTED: begin
                unq = 1'b1;
            end
            default: begin
                // field start (unused codes behave the same)
                l_v = '0;
                if (is_quote) begin
                    sum = sat_add(pos, POS_ONE);
                    s_v = sum[POSITION_BITS-1:0];
                    o_v = o_v | sum[POSITION_BITS];
                    m_v = csvt_pkg::MODE_QUOTED;
                    emit_b = end_of_buffer;
                    b_row  = 1'b1;
                end else begin
                    s_v = pos;
                    unq = 1'b1;
                end
            end
        endcase

        // Unquoted field byte
        if (unq) begin
            if (is_comma) begin
                emit_b = 1'b1;
                b_row  = end_of_buffer;
            end else if (is_lf) begin
                emit_b = 1'b1;
                b_row  = 1'b1;
            end else if (is_cr) begin
                emit_b = end_of_buffer;
                b_row  = 1'b1;
                if (!end_of_buffer) begin
                    m_v = csvt_pkg::MODE_AFTER_CR;
                end
            end else begin
                sum = sat_add(l_v, POS_ONE);
                l_v = sum[POSITION_BITS-1:0];
                o_v = o_v | sum[POSITION_BITS];
                m_v = csvt_pkg::MODE_UNQUOTED;
                emit_b = end_of_buffer;
                b_row  = 1'b1;
            end
        end

        // Second record
        b_close = b_row || (({1'b0, i_v} + 9'd1) >= {1'b0, limit});
        rec_b.field_start       = csvt_pkg::OFFSET_W'(s_v);
        rec_b.field_length      = csvt_pkg::OFFSET_W'(l_v);
        rec_b.field_index       = i_v;
        rec_b.row_end           = b_close;
        rec_b.position_overflow = o_v;
        rec_b.last_of_run       = 1'b1;
        rec_a.last_of_run       = !emit_b;
        if (emit_b) begin
            i_v = b_close ? '0 : csvt_pkg::INDEX_W'(i_v + 8'd1);
            l_v = '0;
            m_v = csvt_pkg::MODE_START;
        end

        // Position advance and end of buffer restart
        if (end_of_buffer) begin
            pos_next   = '0;
            mode_next  = csvt_pkg::MODE_START;
            start_next = '0;
            len_next   = '0;
            index_next = '0;
            ovf_next   = 1'b0;
        end else begin
            mode_next  = m_v;
            start_next = s_v;
            len_next   = l_v;
            index_next = i_v;
            if (pos == POS_MAX) begin
                pos_next = POS_MAX;
                ovf_next = 1'b1;
            end else begin
                pos_next = pos + POS_ONE;
                ovf_next = o_v;
            end
        end
    end

endmodule

// ===== design/csvt_res_fifo.sv =====
module csvt_res_fifo (
    input  logic                              aclk,
    input  logic                              aresetn,
    // write side: up to two records per cycle, first in wr0
    input  logic                              wr0_en,
    input  csvt_pkg::csvt_rec_t               wr0_data,
    input  logic                              wr1_en,
    input  csvt_pkg::csvt_rec_t               wr1_data,
    output logic                              room2,
    // read side
    output logic                              rd_valid,
    input  logic                              rd_ready,
    output csvt_pkg::csvt_rec_t               rd_data
);

    csvt_pkg::csvt_rec_t                 mem [csvt_pkg::RES_DEPTH];
    logic [csvt_pkg::RES_PTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [csvt_pkg::RES_PTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [csvt_pkg::RES_CNT_W-1:0]      cnt_reg, cnt_next;
    logic [csvt_pkg::RES_PTR_W-1:0]      wr_ptr_p1;
    logic                                pop;
    logic [1:0]                          n_push;

    assign wr_ptr_p1 = wr_ptr_reg + csvt_pkg::RES_PTR_W'(1);
    assign pop       = rd_valid && rd_ready;
    assign n_push    = {1'b0, wr0_en} + {1'b0, wr1_en};
    assign rd_valid  = (cnt_reg != '0);
    assign rd_data   = mem[rd_ptr_reg];
    assign room2     = (cnt_reg <= csvt_pkg::RES_CNT_W'(csvt_pkg::RES_DEPTH - 2));

    // Pointer and count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg + csvt_pkg::RES_PTR_W'(n_push);
        rd_ptr_next = pop ? rd_ptr_reg + csvt_pkg::RES_PTR_W'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg + csvt_pkg::RES_CNT_W'(n_push)
                      - csvt_pkg::RES_CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Storage
    always_ff @(posedge aclk) begin
        if (wr0_en) begin
            mem[wr_ptr_reg] <= wr0_data;
        end
        if (wr1_en) begin
            mem[wr_ptr_p1] <= wr1_data;
        end
    end

endmodule

// ===== design/csv_field_tokenizer_core.sv =====
// Channel   Ports                                       Direction  Moves
// s_        s_valid/s_ready, s_data_byte, s_end_of_buf  in         one buffer byte
// m_        m_valid/m_ready, m_field_* , m_row_end ...  out        one field record
// cfg_      cfg_valid/cfg_ready, cfg_max_fields_per_row in         field limit write
//
// One byte per cycle while the queue has room: a byte is held in the input register,
// is parsed and its zero, one or two records enter a four-entry result queue. A byte
// that yields two records is read out as two separate records; input stalls while
// the queue has fewer than two free entries. Reset (aresetn, synchronous)
// clears parser state and sets the field limit to 16; no clearing pass.
module csv_field_tokenizer_core #(
    parameter int POSITION_BITS = csvt_pkg::POSITION_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // input bytes
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [7:0]                        s_data_byte,
    input  logic                              s_end_of_buffer,
    // field records
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [csvt_pkg::OFFSET_W-1:0]     m_field_start,
    output logic [csvt_pkg::OFFSET_W-1:0]     m_field_length,
    output logic [csvt_pkg::INDEX_W-1:0]      m_field_index,
    output logic                              m_row_end,
    output logic                              m_position_overflow,
    output logic                              m_last_of_run,
    // configuration
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [csvt_pkg::INDEX_W-1:0]      cfg_max_fields_per_row
);

    logic                              in_vld_reg;
    logic [7:0]                        in_byte_reg;
    logic                              in_eob_reg;
    logic [csvt_pkg::INDEX_W-1:0]      field_limit_reg;

    logic [POSITION_BITS-1:0]          pos_reg, pos_next;
    csvt_pkg::csvt_mode_t              mode_reg, mode_next;
    logic [POSITION_BITS-1:0]          start_reg, start_next;
    logic [POSITION_BITS-1:0]          len_reg, len_next;
    logic [csvt_pkg::INDEX_W-1:0]      index_reg, index_next;
    logic                              ovf_reg, ovf_next;

    logic                              emit_a, emit_b, room2, advance, s_fire;
    csvt_pkg::csvt_rec_t               rec_a, rec_b, wr0_data, rd_data;

    assign cfg_ready = 1'b1;
    assign advance   = in_vld_reg && room2;
    assign s_ready   = !in_vld_reg || room2;
    assign s_fire    = s_valid && s_ready;

    // Configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            field_limit_reg <= csvt_pkg::FIELD_LIMIT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            field_limit_reg <= cfg_max_fields_per_row;
        end
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_fire) begin
            in_vld_reg <= 1'b1;
        end else if (advance) begin
            in_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_byte_reg <= s_data_byte;
            in_eob_reg  <= s_end_of_buffer;
        end
    end

    // Parser
    csvt_step #(
        .POSITION_BITS (POSITION_BITS)
    ) u_step (
        .data_byte     (in_byte_reg),
        .end_of_buffer (in_eob_reg),
        .field_limit   (field_limit_reg),
        .pos           (pos_reg),
        .mode          (mode_reg),
        .cur_start     (start_reg),
        .cur_len       (len_reg),
        .cur_index     (index_reg),
        .cur_ovf       (ovf_reg),
        .pos_next      (pos_next),
        .mode_next     (mode_next),
        .start_next    (start_next),
        .len_next      (len_next),
        .index_next    (index_next),
        .ovf_next      (ovf_next),
        .emit_a        (emit_a),
        .rec_a         (rec_a),
        .emit_b        (emit_b),
        .rec_b         (rec_b)
    );

    // Parser state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            mode_reg  <= csvt_pkg::MODE_START;
            start_reg <= '0;
            len_reg   <= '0;
            index_reg <= '0;
            ovf_reg   <= 1'b0;
        end else if (advance) begin
            pos_reg   <= pos_next;
            mode_reg  <= mode_next;
            start_reg <= start_next;
            len_reg   <= len_next;
            index_reg <= index_next;
            ovf_reg   <= ovf_next;
        end
    end

    // A single record always goes into the first write slot
    assign wr0_data = emit_a ? rec_a : rec_b;

    csvt_res_fifo u_res_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr0_en   (advance && (emit_a || emit_b)),
        .wr0_data (wr0_data),
        .wr1_en   (advance && emit_a && emit_b),
        .wr1_data (rec_b),
        .room2    (room2),
        .rd_valid (m_valid),
        .rd_ready (m_ready),
        .rd_data  (rd_data)
    );

    assign m_field_start       = rd_data.field_start;
    assign m_field_length      = rd_data.field_length;
    assign m_field_index       = rd_data.field_index;
    assign m_row_end           = rd_data.row_end;
    assign m_position_overflow = rd_data.position_overflow;
    assign m_last_of_run       = rd_data.last_of_run;

endmodule
